// File: rtl/csx_pkg.sv
// Shared types, status codes and helpers for the CAN signal extractor.
package csx_pkg;

    localparam int FRAME_BITS = 64;
    localparam int VALUE_BITS = 32;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_PAST    = 2'd2;

    // Decode stage -> shift stage
    typedef struct packed {
        logic [FRAME_BITS-1:0] src;
        logic [5:0]            shamt;
        logic [5:0]            len;
        logic                  sgn;
        logic [1:0]            status;
    } dec_t;

    // Shift stage -> format stage
    typedef struct packed {
        logic [VALUE_BITS-1:0] raw;
        logic [5:0]            len;
        logic                  sgn;
        logic [1:0]            status;
    } shf_t;

    // Byte order reversal; puts Motorola sawtooth order MSB-first at the top
    function automatic logic [FRAME_BITS-1:0] byte_swap(input logic [FRAME_BITS-1:0] d);
        logic [FRAME_BITS-1:0] r;
        for (int b = 0; b < FRAME_BITS / 8; b++) begin
            r[8*b +: 8] = d[FRAME_BITS - 8 - 8*b +: 8];
        end
        return r;
    endfunction

endpackage

// File: rtl/csx_decode.sv
// Stage 1: layout decode, range checks, source select and shift amount.
module csx_decode #(
    parameter int FRAME_BYTES     = 8,
    parameter int MAX_SIGNAL_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [63:0]         frame_data,
    input  logic [5:0]          start_bit,
    input  logic [5:0]          bit_length,
    input  logic                motorola_order,
    input  logic                is_signed,
    output logic                out_valid,
    input  logic                out_ready,
    output csx_pkg::dec_t       out_data
);

    logic          valid_reg;
    csx_pkg::dec_t data_reg;
    csx_pkg::dec_t data_next;
    logic [5:0]    lin0;
    logic [6:0]    last_idx;
    logic [6:0]    moto_sh;
    logic          bad_len;
    logic          past;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        // Motorola: bit k of byte b maps to linear index b*8 + (7-k)
        lin0     = motorola_order ? {start_bit[5:3], ~start_bit[2:0]} : start_bit;
        last_idx = {1'b0, lin0} + {1'b0, bit_length} - 7'd1;
        moto_sh  = 7'd64 - {1'b0, lin0} - {1'b0, bit_length};
        bad_len  = (bit_length == 6'd0) || ({1'b0, bit_length} > 7'(MAX_SIGNAL_BITS));
        past     = last_idx >= 7'(FRAME_BYTES * 8);

        data_next.len = bit_length;
        data_next.sgn = is_signed;
        if (bad_len) begin
            data_next.status = csx_pkg::ST_BAD_LEN;
        end else if (past) begin
            data_next.status = csx_pkg::ST_PAST;
        end else begin
            data_next.status = csx_pkg::ST_OK;
        end
        if (motorola_order) begin
            data_next.src   = csx_pkg::byte_swap(frame_data);
            data_next.shamt = moto_sh[5:0];
        end else begin
            data_next.src   = frame_data;
            data_next.shamt = start_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/csx_shift.sv
// Stage 2: barrel shift of the selected payload word.
module csx_shift (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  csx_pkg::dec_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output csx_pkg::shf_t  out_data
);

    logic                           valid_reg;
    csx_pkg::shf_t                  data_reg;
    csx_pkg::shf_t                  data_next;
    logic [csx_pkg::FRAME_BITS-1:0] shifted;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        shifted          = in_data.src >> in_data.shamt;
        data_next.raw    = shifted[csx_pkg::VALUE_BITS-1:0];
        data_next.len    = in_data.len;
        data_next.sgn    = in_data.sgn;
        data_next.status = in_data.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/csx_format.sv
// Stage 3: length mask, sign extension and error zeroing into the output register.
module csx_format (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  csx_pkg::shf_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_value,
    output logic [1:0]     out_status
);

    logic        valid_reg;
    logic [31:0] value_reg;
    logic [31:0] value_next;
    logic [1:0]  status_reg;
    logic [32:0] mask_wide;
    logic [31:0] mask;
    logic [4:0]  top_idx;
    logic        sign_bit;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;

    always_comb begin
        mask_wide = (33'd1 << in_data.len) - 33'd1;
        mask      = mask_wide[31:0];
        top_idx   = 5'(in_data.len - 6'd1);
        sign_bit  = in_data.raw[top_idx];
        if (in_data.status != csx_pkg::ST_OK) begin
            value_next = '0;
        end else if (in_data.sgn && sign_bit) begin
            value_next = in_data.raw | ~mask;
        end else begin
            value_next = in_data.raw & mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            value_reg  <= value_next;
            status_reg <= in_data.status;
        end
    end

endmodule

// File: rtl/can_signal_extract.sv
// Top level: three-stage CAN signal extractor (Intel and Motorola layouts).
//
//  channel | dir | tdata (low bit up)                        | tuser
//  s_      | in  | frame_data 64, start_bit 6, bit_length 6  | motorola_order, is_signed
//  m_      | out | value 32                                  | status 2
//
// Requests pass the decode, shift and format registers; one per cycle unless m_tready stalls.
// Stages: decode and range check, 64-bit barrel shift, mask and sign extend.
// Reset clears only the stage valid bits.
// A stall on m_tready backs up stage by stage; empty stages still take requests.
module can_signal_extract #(
    parameter int FRAME_BYTES     = 8,
    parameter int MAX_SIGNAL_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // frame_data[63:0], start_bit[69:64], bit_length[75:70], zero pad
    input  logic [1:0]  s_tuser,   // motorola_order[0], is_signed[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value[31:0]
    output logic [1:0]  m_tuser    // status[1:0]
);

    logic          dec_valid;
    logic          dec_ready;
    csx_pkg::dec_t dec_data;
    logic          shf_valid;
    logic          shf_ready;
    csx_pkg::shf_t shf_data;

    csx_decode #(
        .FRAME_BYTES     (FRAME_BYTES),
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .frame_data     (s_tdata[63:0]),
        .start_bit      (s_tdata[69:64]),
        .bit_length     (s_tdata[75:70]),
        .motorola_order (s_tuser[0]),
        .is_signed      (s_tuser[1]),
        .out_valid      (dec_valid),
        .out_ready      (dec_ready),
        .out_data       (dec_data)
    );

    csx_shift u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (shf_valid),
        .out_ready (shf_ready),
        .out_data  (shf_data)
    );

    csx_format u_format (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (shf_valid),
        .in_ready   (shf_ready),
        .in_data    (shf_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

endmodule

// File: rtl/csx_checker.sv
// Port-level checker for the CAN signal extractor, with its bind.
module csx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != csx_pkg::ST_OK |-> m_tdata == 32'd0)
        else $error("error status with nonzero value");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code");

    // accepted request reaches the output when the sink keeps taking
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("request did not reach output in three cycles");

endmodule

bind can_signal_extract csx_checker u_csx_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
